@@ hw/rtl/slid_pkg.sv @@
// Shared types and constants for the sorted list insert/delete unit.
package slid_pkg;

  localparam int unsigned ValW  = 16;
  localparam int unsigned CmdW  = 2;
  localparam int unsigned StatW = 2;
  localparam int unsigned OccW  = 6;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_DUMP   = 2'd2
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_e;

  typedef enum logic {
    S_IDLE,
    S_DUMP
  } state_e;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [ValW-1:0]   value;
  } cell_ctrl_t;

  // Flip the sign bit so two's complement order becomes unsigned order
  function automatic logic [ValW-1:0] order_key(input logic [ValW-1:0] v);
    order_key = {~v[ValW-1], v[ValW-2:0]};
  endfunction

endpackage

@@ hw/rtl/slid_cell.sv @@
// One slot of the sorted shift array: holds a value and moves it left or right.
module slid_cell (
  input  logic                        clk_i,
  input  slid_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        occupied_i,
  input  logic                        tail_i,
  input  logic                        left_stay_i,
  input  logic [slid_pkg::ValW-1:0]   left_val_i,
  input  logic [slid_pkg::ValW-1:0]   right_val_i,
  input  logic [slid_pkg::ValW-1:0]   head_val_i,
  output logic [slid_pkg::ValW-1:0]   value_o,
  output logic                        stay_o,
  output logic                        match_o
);
  import slid_pkg::*;

  logic [ValW-1:0] value_q, value_d;
  logic [ValW-1:0] key_own, key_in;
  logic            ge;

  assign key_own = order_key(value_q);
  assign key_in  = order_key(ctrl_i.value);

  // Compare flags; insert goes after equal entries
  assign stay_o  = occupied_i && (key_own <= key_in);
  assign ge      = occupied_i && (key_own >= key_in);
  assign match_o = occupied_i && (value_q == ctrl_i.value);
  assign value_o = value_q;

  // Next value from the broadcast operation
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      OP_INSERT: begin
        if (!stay_o) begin
          value_d = left_stay_i ? ctrl_i.value : left_val_i;
        end
      end
      OP_DELETE: begin
        if (ge) begin
          value_d = right_val_i;
        end
      end
      OP_ROTATE: begin
        value_d = tail_i ? head_val_i : right_val_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

@@ hw/rtl/sorted_list_insert_delete_unit.sv @@
// Top level: sorted multiset with insert, delete and ordered dump.
// Insert and delete: result in the cycle after accept; one command per cycle while busy is low.
// Dump of n elements: accept enters S_DUMP, then each of the n results is registered from the head cell;
// results come back to back and busy is high while the cell row rotates through the head cell.
// Empty dump and unused commands give one result in the cycle after accept; results never stall.
// Reset clears the element count and control; cell contents stay undefined until written.
module sorted_list_insert_delete_unit #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [slid_pkg::CmdW-1:0]    command_i,
  input  logic signed [slid_pkg::ValW-1:0] value_i,
  output logic                         result_valid_o,
  output logic [slid_pkg::StatW-1:0]   status_o,
  output logic signed [slid_pkg::ValW-1:0] element_o,
  output logic [slid_pkg::OccW-1:0]    occupancy_o,
  output logic                         last_o
);
  import slid_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  state_e          state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            res_valid_q, res_valid_d;
  status_e         status_q, status_d;
  logic [ValW-1:0] element_q, element_d;
  logic            last_q, last_d;

  cell_ctrl_t      ctrl;
  logic            accept, full, found;
  logic [CntW-1:0] count_m1;

  logic [ValW-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0] cell_stay, cell_match;

  assign accept   = start && !busy;
  assign busy     = (state_q == S_DUMP);
  assign full     = (count_q == CntW'(CAPACITY));
  assign found    = |cell_match;
  assign count_m1 = count_q - CntW'(1);

  // Row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                occ, tail, lstay;
    logic [ValW-1:0]     lval, rval;
    assign occ  = (CntW'(i) < count_q);
    assign tail = (CntW'(i) == count_m1);
    if (i == 0) begin : g_head
      assign lstay = 1'b1;
      assign lval  = ctrl.value;
    end else begin : g_mid
      assign lstay = cell_stay[i-1];
      assign lval  = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_end
      assign rval = cell_val[i];
    end else begin : g_nxt
      assign rval = cell_val[i+1];
    end
    slid_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (occ),
      .tail_i      (tail),
      .left_stay_i (lstay),
      .left_val_i  (lval),
      .right_val_i (rval),
      .head_val_i  (cell_val[0]),
      .value_o     (cell_val[i]),
      .stay_o      (cell_stay[i]),
      .match_o     (cell_match[i])
    );
  end

  // Command decode, dump sequencing and result formation
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ctrl.op     = OP_HOLD;
    ctrl.value  = value_i;
    res_valid_d = 1'b0;
    status_d    = ST_DONE;
    element_d   = value_i;
    last_d      = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          case (cmd_e'(command_i))
            CMD_INSERT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                ctrl.op = OP_INSERT;
                count_d = count_q + CntW'(1);
              end
            end
            CMD_DELETE: begin
              if (!found) begin
                status_d = ST_NOT_FOUND;
              end else begin
                ctrl.op = OP_DELETE;
                count_d = count_m1;
              end
            end
            CMD_DUMP: begin
              if (count_q == '0) begin
                status_d  = ST_EMPTY;
                element_d = '0;
              end else begin
                res_valid_d = 1'b0;
                state_d     = S_DUMP;
                idx_d       = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_DUMP: begin
        res_valid_d = 1'b1;
        element_d   = cell_val[0];
        ctrl.op     = OP_ROTATE;
        last_d      = (idx_q == count_m1);
        if (last_d) begin
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign element_o      = element_q;
  assign occupancy_o    = OccW'(count_q);
  assign last_o         = last_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("element count above capacity");

  a_full_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (command_i == CMD_INSERT) && full
    |=> result_valid_o && (status_o == ST_FULL) && $stable(count_q))
    else $error("insert into full store not rejected");

  a_dump_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> result_valid_o)
    else $error("dump stream broke before last");

  a_dump_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |=> element_o >= $past(element_o))
    else $error("dump out of order");

  a_dump_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> $stable(count_q))
    else $error("count changed during dump");

endmodule
